### sv/sdm_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdm_pkg
// Shared types, constants and helpers of the scene distance engine.
// -----------------------------------------------------------------------------
package sdm_pkg;

   localparam int MAX_OBJECTS = 64;
   localparam int OBJ_IDX_W   = $clog2(MAX_OBJECTS);
   localparam int COUNT_W     = 7;
   localparam int DIST_W      = 31;

   localparam logic [DIST_W-1:0] RENDER_RESET = 31'd6553600;
   localparam logic signed [31:0] SAT31_POS   = 32'sh7fffffff;
   localparam logic signed [31:0] SAT31_NEG   = -32'sh7fffffff;

   // item operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // object kinds
   localparam logic [1:0] KIND_SPHERE   = 2'd0;
   localparam logic [1:0] KIND_CYLINDER = 2'd1;
   localparam logic [1:0] KIND_PLANE    = 2'd2;

   // csr register indexes
   localparam logic CSR_OBJECT_COUNT    = 1'b0;
   localparam logic CSR_RENDER_DISTANCE = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [5:0]        slot;
      logic [1:0]        kind;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic [30:0]       radius;
      logic [30:0]       height;
   } item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic [30:0]        radius;
      logic [30:0]        height;
   } object_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEXT,
      ST_READ,
      ST_DIFF,
      ST_MAC,
      ST_ACC_DONE,
      ST_OFFSET,
      ST_SQRT,
      ST_CMP,
      ST_DONE
   } back_state_type;

   // saturate a signed value to +-(2^31-1)
   function automatic logic signed [31:0] sat31(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007fffffff) r = SAT31_POS;
      else if (v < -40'sh007fffffff) r = SAT31_NEG;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### sv/sdm_front.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdm_front
// Input side: takes request beats into a two-entry queue for the back end.
// -----------------------------------------------------------------------------
module sdm_front import sdm_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire item_type req_item,
   output logic          item_valid,
   output item_type      item,
   input  wire logic     item_pop
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (fill_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule
`default_nettype wire

### sv/sdm_sqrt.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdm_sqrt
// Iterative integer square root of a 64-bit value, one result bit a cycle.
// -----------------------------------------------------------------------------
module sdm_sqrt import sdm_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);

   logic [63:0] x_ff, x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] trial;

   assign done  = done_ff;
   assign root  = res_ff[31:0];
   assign trial = res_ff + bit_ff;

   // one restoring step per cycle
   always_comb begin
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == 64'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

endmodule
`default_nettype wire

### sv/sdm_back.sv
`default_nettype none
// -----------------------------------------------------------------------------
// sdm_back
// Back end: object table, per-object distance sequencer and result register.
// -----------------------------------------------------------------------------
module sdm_back import sdm_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire item_type            item,
   output logic                     item_pop,
   input  wire logic [COUNT_W-1:0]  object_count,
   input  wire logic [DIST_W-1:0]   range_limit,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [DIST_W-1:0]        rsp_distance,
   output logic [OBJ_IDX_W-1:0]     rsp_hit_index,
   output logic                     rsp_hit_found
);

   object_type mem [MAX_OBJECTS];
   object_type rd_ff;

   back_state_type state_ff, state_in;
   item_type       point_ff, point_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic signed [31:0] v_ff [3];
   logic signed [31:0] v_in [3];
   logic signed [65:0] acc_ff, acc_in;
   logic [1:0]         k_ff, k_in;
   logic               sq_mode_ff, sq_mode_in;
   logic               rim_ff, rim_in;
   logic signed [35:0] h_ff, h_in;
   logic [35:0]        dist_ff, dist_in;
   logic [DIST_W-1:0]  best_ff, best_in;
   logic [OBJ_IDX_W-1:0] hit_ff, hit_in;
   logic               found_ff, found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  rsp_dist_ff, rsp_dist_in;
   logic [OBJ_IDX_W-1:0] rsp_hit_ff, rsp_hit_in;
   logic               rsp_found_ff, rsp_found_in;

   logic               mem_we;
   object_type         wr_obj;
   logic [COUNT_W-1:0] n_obj;
   logic               sqrt_start;
   logic               sqrt_done;
   logic [31:0]        sqrt_root;

   logic signed [31:0] v_sel, opb;
   logic signed [15:0] ax_sel;
   logic signed [63:0] prod;
   logic signed [51:0] offp;
   logic signed [37:0] offs;
   logic signed [39:0] odiff;
   logic signed [65:0] acc_abs;
   logic signed [35:0] h_abs;
   logic [35:0]        hh;
   logic               in_band;
   logic [35:0]        b_len;
   logic [32:0]        rim_e;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_hit_index = rsp_hit_ff;
   assign rsp_hit_found = rsp_found_ff;

   assign n_obj = (object_count > COUNT_W'(MAX_OBJECTS)) ? COUNT_W'(MAX_OBJECTS)
                                                         : object_count;

   // object table write from a load beat
   assign mem_we = (state_ff == ST_IDLE) && item_valid && (item.operation == OP_LOAD);
   assign wr_obj = '{kind: item.kind, cx: item.pos_x, cy: item.pos_y, cz: item.pos_z,
                     ax: item.axis_x, ay: item.axis_y, az: item.axis_z,
                     radius: item.radius, height: item.height};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[item.slot] <= wr_obj;
      end
      rd_ff <= mem[idx_ff[OBJ_IDX_W-1:0]];
   end

   // shared multipliers
   always_comb begin
      case (k_ff)
         2'd0:    begin v_sel = v_ff[0]; ax_sel = rd_ff.ax; end
         2'd1:    begin v_sel = v_ff[1]; ax_sel = rd_ff.ay; end
         default: begin v_sel = v_ff[2]; ax_sel = rd_ff.az; end
      endcase
   end
   assign opb     = sq_mode_ff ? v_sel : {{16{ax_sel[15]}}, ax_sel};
   assign prod    = v_sel * opb;
   assign offp    = $signed({{36{ax_sel[15]}}, ax_sel}) * $signed({{16{h_ff[35]}}, h_ff});
   assign offs    = offp[51:14];
   assign odiff   = {{8{v_sel[31]}}, v_sel} - {{2{offs[37]}}, offs};
   assign acc_abs = acc_ff[65] ? -acc_ff : acc_ff;

   // cylinder band and cap terms
   assign h_abs   = h_ff[35] ? -h_ff : h_ff;
   assign hh      = {6'd0, rd_ff.height[30:1]};
   assign in_band = (h_ff < $signed(hh)) && (h_ff > -$signed(hh));
   assign b_len   = h_abs - hh;
   assign rim_e   = {1'b0, sqrt_root} - {2'b0, rd_ff.radius};

   sdm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (acc_ff[63:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      point_in     = point_ff;
      idx_in       = idx_ff;
      v_in         = v_ff;
      acc_in       = acc_ff;
      k_in         = k_ff;
      sq_mode_in   = sq_mode_ff;
      rim_in       = rim_ff;
      h_in         = h_ff;
      dist_in      = dist_ff;
      best_in      = best_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_dist_in  = rsp_dist_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_found_in = rsp_found_ff;
      item_pop     = 1'b0;
      sqrt_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.operation == OP_QUERY) begin
                  point_in = item;
                  idx_in   = '0;
                  best_in  = range_limit;
                  hit_in   = '0;
                  found_in = 1'b0;
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            state_in = (idx_ff == n_obj) ? ST_DONE : ST_READ;
         end
         ST_READ: begin
            state_in = ST_DIFF;
         end
         // point minus centre, saturated
         ST_DIFF: begin
            v_in[0] = sat31(40'(point_ff.pos_x) - 40'(rd_ff.cx));
            v_in[1] = sat31(40'(point_ff.pos_y) - 40'(rd_ff.cy));
            v_in[2] = sat31(40'(point_ff.pos_z) - 40'(rd_ff.cz));
            acc_in     = '0;
            k_in       = '0;
            rim_in     = 1'b0;
            sq_mode_in = (rd_ff.kind == KIND_SPHERE);
            if (rd_ff.kind == KIND_SPHERE || rd_ff.kind == KIND_CYLINDER ||
                rd_ff.kind == KIND_PLANE) begin
               state_in = ST_MAC;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_NEXT;
            end
         end
         // dot product or sum of squares, one term a cycle
         ST_MAC: begin
            acc_in = acc_ff + {{2{prod[63]}}, prod};
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               state_in = ST_ACC_DONE;
            end
         end
         ST_ACC_DONE: begin
            k_in = '0;
            if (sq_mode_ff) begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT;
            end else if (rd_ff.kind == KIND_PLANE) begin
               dist_in  = acc_abs[49:14];
               state_in = ST_CMP;
            end else begin
               h_in     = acc_ff[49:14];
               state_in = ST_OFFSET;
            end
         end
         // radial offset from the cylinder axis
         ST_OFFSET: begin
            v_in[k_ff] = sat31(odiff);
            k_in       = k_ff + 2'd1;
            if (k_ff == 2'd2) begin
               k_in       = '0;
               acc_in     = '0;
               sq_mode_in = 1'b1;
               state_in   = ST_MAC;
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_CMP;
               if (rd_ff.kind == KIND_SPHERE ||
                   (rd_ff.kind == KIND_CYLINDER && !rim_ff && in_band)) begin
                  dist_in = (sqrt_root > {1'b0, rd_ff.radius})
                          ? 36'(rim_e) : '0;
               end else if (rim_ff) begin
                  dist_in = {4'd0, sqrt_root};
               end else if (sqrt_root < {1'b0, rd_ff.radius}) begin
                  dist_in = b_len;
               end else begin
                  // rim point: length of (r - radius, cap distance)
                  v_in[0] = (rim_e > 33'h7fffffff) ? SAT31_POS : rim_e[31:0];
                  v_in[1] = (b_len > 36'h7fffffff) ? SAT31_POS : b_len[31:0];
                  v_in[2] = '0;
                  acc_in  = '0;
                  k_in    = '0;
                  rim_in  = 1'b1;
                  state_in = ST_MAC;
               end
            end
         end
         ST_CMP: begin
            if (dist_ff < {5'd0, best_ff}) begin
               best_in  = dist_ff[DIST_W-1:0];
               hit_in   = idx_ff[OBJ_IDX_W-1:0];
               found_in = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = ST_NEXT;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = best_ff;
               rsp_hit_in   = hit_ff;
               rsp_found_in = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      point_ff     <= point_in;
      idx_ff       <= idx_in;
      v_ff         <= v_in;
      acc_ff       <= acc_in;
      k_ff         <= k_in;
      sq_mode_ff   <= sq_mode_in;
      rim_ff       <= rim_in;
      h_ff         <= h_in;
      dist_ff      <= dist_in;
      best_ff      <= best_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_found_ff <= rsp_found_in;
   end

endmodule
`default_nettype wire

### sv/scene_min_distance.sv
`default_nettype none
// -----------------------------------------------------------------------------
// scene_min_distance
// Distance engine for ray marching over a table of spheres, capped
// cylinders and planes.
// -----------------------------------------------------------------------------
// A load beat (tuser 0) writes one object into the 64-entry table. A query
// beat (tuser 1) walks objects 0 to min(object_count, 64)-1 through one
// shared multiply-accumulate and an iterative square root that yields one
// bit a cycle: a sphere passes the square root once, a capped cylinder once,
// or twice when its rim point is used, a plane only the multiply-accumulate,
// and an unknown kind is skipped. Beats are queued two deep, so the next
// beat is taken while one is being worked on.
module scene_min_distance import sdm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   // request: tdata = slot, kind, pos_x, pos_y, pos_z, axis_x, axis_y,
   // axis_z, radius, height (lowest first); tuser = operation
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [215:0]  req_tdata,
   input  wire logic          req_tuser,
   // response: tdata = distance, hit_index; tuser = hit_found
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [39:0]        rsp_tdata,
   output logic               rsp_tuser,
   // register writes
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [30:0]   csr_wdata
);

   logic [COUNT_W-1:0] object_count_ff;
   logic [DIST_W-1:0]  range_limit_ff;
   item_type           req_item;
   item_type           item;
   logic               item_valid;
   logic               item_pop;
   logic [DIST_W-1:0]  rsp_distance;
   logic [OBJ_IDX_W-1:0] rsp_hit_index;

   // unpack request beat
   assign req_item = '{operation: req_tuser,
                       slot:   req_tdata[5:0],
                       kind:   req_tdata[7:6],
                       pos_x:  req_tdata[39:8],
                       pos_y:  req_tdata[71:40],
                       pos_z:  req_tdata[103:72],
                       axis_x: req_tdata[119:104],
                       axis_y: req_tdata[135:120],
                       axis_z: req_tdata[151:136],
                       radius: req_tdata[182:152],
                       height: req_tdata[213:183]};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         object_count_ff <= '0;
         range_limit_ff  <= RENDER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OBJECT_COUNT:    object_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_RENDER_DISTANCE: range_limit_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   sdm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   sdm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop),
      .object_count    (object_count_ff),
      .range_limit     (range_limit_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_distance    (rsp_distance),
      .rsp_hit_index   (rsp_hit_index),
      .rsp_hit_found   (rsp_tuser)
   );

   // pack response beat
   assign rsp_tdata = {3'd0, rsp_hit_index, rsp_distance};

endmodule
`default_nettype wire

### test/scene_min_distance_check.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// scene_min_distance_check
// Watches the request, response and register ports of the distance engine,
// keeps its own object table, predicts the nearest object for every query
// and compares each response beat field by field.
// -----------------------------------------------------------------------------
module scene_min_distance_check import sdm_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [215:0]  req_tdata,
   input  wire logic          req_tuser,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic [39:0]   rsp_tdata,
   input  wire logic          rsp_tuser,
   input  wire logic          csr_we,
   input  wire logic          csr_index,
   input  wire logic [30:0]   csr_wdata,
   output int                 fail_count,
   output int                 outstanding,
   output int                 hit_count
);

   typedef struct {
      longint distance;
      int     hit_index;
      bit     hit_found;
   } nearest_type;

   // shadow of the object table and registers
   bit [1:0]    obj_kind [MAX_OBJECTS];
   longint      obj_c    [MAX_OBJECTS][3];
   longint      obj_a    [MAX_OBJECTS][3];
   longint      obj_rad  [MAX_OBJECTS];
   longint      obj_hgt  [MAX_OBJECTS];
   int          search_count;
   longint      render_limit;

   nearest_type nearest_q[$];

   function automatic longint clip31(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
   endfunction

   // bitwise integer square root, floor
   function automatic longint int_sqrt(input bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return longint'(res);
   endfunction

   // components are already clipped to 31 bits
   function automatic longint vec_length(input longint a, input longint b, input longint c);
      bit [63:0] s;
      s = 64'(a * a) + 64'(b * b) + 64'(c * c);
      return int_sqrt(s);
   endfunction

   function automatic longint cylinder_distance(input longint d[3], input int i);
      longint h;
      longint hh;
      longint o[3];
      longint r;
      longint b;
      h = (d[0] * obj_a[i][0] + d[1] * obj_a[i][1] + d[2] * obj_a[i][2]) >>> 14;
      for (int k = 0; k < 3; k++) o[k] = clip31(d[k] - ((obj_a[i][k] * h) >>> 14));
      r = vec_length(o[0], o[1], o[2]);
      hh = obj_hgt[i] >> 1;
      // between the caps: radial distance only
      if (h < hh && h > -hh) return (r > obj_rad[i]) ? r - obj_rad[i] : 0;
      b = (h < 0 ? -h : h) - hh;
      // over a cap face, else towards the rim
      if (r < obj_rad[i]) return b;
      return vec_length(clip31(r - obj_rad[i]), clip31(b), 0);
   endfunction

   function automatic nearest_type nearest_object(input longint px, input longint py,
                                                  input longint pz);
      nearest_type res;
      longint d[3];
      longint obj_dist;
      longint v;
      int n;
      bit known;
      res.distance = render_limit;
      res.hit_index = 0;
      res.hit_found = 0;
      n = (search_count > MAX_OBJECTS) ? MAX_OBJECTS : search_count;
      for (int i = 0; i < n; i++) begin
         d[0] = clip31(px - obj_c[i][0]);
         d[1] = clip31(py - obj_c[i][1]);
         d[2] = clip31(pz - obj_c[i][2]);
         known = 1;
         obj_dist = 0;
         case (obj_kind[i])
            KIND_SPHERE: begin
               v = vec_length(d[0], d[1], d[2]);
               obj_dist = (v > obj_rad[i]) ? v - obj_rad[i] : 0;
            end
            KIND_CYLINDER: obj_dist = cylinder_distance(d, i);
            KIND_PLANE: begin
               v = d[0] * obj_a[i][0] + d[1] * obj_a[i][1] + d[2] * obj_a[i][2];
               obj_dist = (v < 0 ? -v : v) >> 14;
            end
            default: known = 0;
         endcase
         // strict compare, so the first object keeps a tie
         if (known && obj_dist < res.distance) begin
            res.distance = obj_dist;
            res.hit_index = i;
            res.hit_found = 1;
         end
      end
      return res;
   endfunction

   assign outstanding = nearest_q.size();

   always @(posedge clock) begin
      nearest_type want;
      int s;
      if (reset) begin
         for (int i = 0; i < MAX_OBJECTS; i++) begin
            obj_kind[i] = 0;
            obj_rad[i] = 0;
            obj_hgt[i] = 0;
            for (int k = 0; k < 3; k++) begin
               obj_c[i][k] = 0;
               obj_a[i][k] = 0;
            end
         end
         search_count = 0;
         render_limit = RENDER_RESET;
         nearest_q.delete();
         fail_count = 0;
         hit_count = 0;
      end else begin
         // response beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (nearest_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response beat with nothing expected: tdata %h tuser %b",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               want = nearest_q.pop_front();
               if (rsp_tuser) hit_count++;
               if (rsp_tdata[30:0] != want.distance[30:0] ||
                   rsp_tdata[36:31] != want.hit_index[5:0] ||
                   rsp_tuser != want.hit_found) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: distance %0d/%0d index %0d/%0d found %0b/%0b (exp/got)",
                              $realtime, want.distance, rsp_tdata[30:0], want.hit_index,
                              rsp_tdata[36:31], want.hit_found, rsp_tuser);
               end
            end
         end
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_OBJECT_COUNT) search_count = int'(csr_wdata[6:0]);
            else render_limit = longint'(csr_wdata);
         end
         // request beat: load into the table or predict a query
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_LOAD) begin
               s = int'(req_tdata[5:0]);
               obj_kind[s] = req_tdata[7:6];
               obj_c[s][0] = longint'($signed(req_tdata[39:8]));
               obj_c[s][1] = longint'($signed(req_tdata[71:40]));
               obj_c[s][2] = longint'($signed(req_tdata[103:72]));
               obj_a[s][0] = longint'($signed(req_tdata[119:104]));
               obj_a[s][1] = longint'($signed(req_tdata[135:120]));
               obj_a[s][2] = longint'($signed(req_tdata[151:136]));
               obj_rad[s] = longint'(req_tdata[182:152]);
               obj_hgt[s] = longint'(req_tdata[213:183]);
            end else begin
               nearest_q.push_back(nearest_object(longint'($signed(req_tdata[39:8])),
                                                  longint'($signed(req_tdata[71:40])),
                                                  longint'($signed(req_tdata[103:72]))));
            end
         end
      end
   end

endmodule

### test/scene_min_distance_tb.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// scene_min_distance_tb
// Drives loads and queries into the distance engine under several register
// settings and handshake patterns; the checker beside it does the scoring.
// -----------------------------------------------------------------------------
module scene_min_distance_tb import sdm_pkg::*;;

   localparam int         ONE         = 65536;
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         QUIET_LIMIT = 60000;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [215:0]  req_tdata;
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [39:0]   rsp_tdata;
   logic          rsp_tuser;
   logic          csr_we;
   logic          csr_index;
   logic [30:0]   csr_wdata;

   int fail_count;
   int outstanding;
   int hit_count;
   int send_idle_pct;
   int stall_pct;
   int hold_left;
   int quiet_cycles;
   int load_total;
   int query_total;

   scene_min_distance u_top (.*);

   scene_min_distance_check u_check (.*);

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // result side: random stalls, plus one long hold-off
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic item_type make_item(input logic op, input int slot, input logic [1:0] kind,
                                          input int x, input int y, input int z,
                                          input int ax, input int ay, input int az,
                                          input int unsigned rad, input int unsigned hgt);
      item_type it;
      it.operation = op;
      it.slot = slot[5:0];
      it.kind = kind;
      it.pos_x = x;
      it.pos_y = y;
      it.pos_z = z;
      it.axis_x = ax[15:0];
      it.axis_y = ay[15:0];
      it.axis_z = az[15:0];
      it.radius = rad[30:0];
      it.height = hgt[30:0];
      return it;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(19))
         0: return int'($urandom);
         1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
         default: return int'($urandom_range(1 << 24)) - (1 << 23);
      endcase
   endfunction

   function automatic int unsigned rand_length();
      case ($urandom_range(9))
         0: return $urandom & 32'h7fffffff;
         1: return 0;
         default: return $urandom_range(1 << 22);
      endcase
   endfunction

   function automatic item_type rand_item(input logic op, input int slot);
      int a[3];
      int k;
      int sgn;
      k = $urandom_range(2);
      sgn = $urandom_range(1) ? 16384 : -16384;
      a = '{0, 0, 0};
      case ($urandom_range(5))
         0, 1, 2: a[k] = sgn;
         3: begin
            a[k] = (sgn > 0) ? 11585 : -11585;
            a[(k + 1) % 3] = $urandom_range(1) ? 11585 : -11585;
         end
         default: for (int j = 0; j < 3; j++) a[j] = int'($urandom_range(32768)) - 16384;
      endcase
      return make_item(op, slot, 2'($urandom_range(15) == 0 ? KIND_UNUSED : $urandom_range(2)),
                       rand_coord(), rand_coord(), rand_coord(), a[0], a[1], a[2],
                       rand_length(), rand_length());
   endfunction

   task automatic send(input item_type it);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.operation;
      req_tdata <= {2'b00, it.height, it.radius, it.axis_z, it.axis_y, it.axis_x,
                    it.pos_z, it.pos_y, it.pos_x, it.kind, it.slot};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      if (it.operation == OP_LOAD) load_total++;
      else query_total++;
   endtask

   // drain all responses, then let trailing loads finish
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (60) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[30:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   int          ph_count [5] = '{6, 16, 127, 3, 64};
   int unsigned ph_render[5] = '{6553600, 32'h7fffffff, 0, 0, 6553600};
   int          ph_items [5] = '{170, 170, 50, 170, 20};
   int          ph_idle  [5] = '{0, 79, 0, 7, 0};
   int          ph_stall [5] = '{0, 0, 79, 7, 0};

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_LOAD;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_OBJECT_COUNT;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      quiet_cycles = 0;
      load_total = 0;
      query_total = 0;
      ph_render[3] = $urandom_range(1, 1 << 24);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty search straight after reset
      send(make_item(OP_QUERY, 0, KIND_SPHERE, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, 0));

      // hand-placed objects: unit sphere, cylinder along z, floor plane,
      // unknown kind, far extremes, skewed axis and a copy of slot 0 for ties
      send(make_item(OP_LOAD, 0, KIND_SPHERE, 0, 0, 0, 0, 0, 0, ONE, 0));
      send(make_item(OP_LOAD, 1, KIND_CYLINDER, 10 * ONE, 0, 0, 0, 0, 16384,
                     2 * ONE, 4 * ONE));
      send(make_item(OP_LOAD, 2, KIND_PLANE, 0, -5 * ONE, 0, 0, 16384, 0, 0, 0));
      send(make_item(OP_LOAD, 3, KIND_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
      send(make_item(OP_LOAD, 4, KIND_SPHERE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     -16384, -16384, -16384, 32'h7fffffff, 32'h7fffffff));
      send(make_item(OP_LOAD, 5, KIND_CYLINDER, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     16384, 16384, 16384, 0, 32'h7fffffff));
      send(make_item(OP_LOAD, 6, KIND_PLANE, 3 * ONE, 0, 0, -16384, 9000, 16384, 0, 0));
      send(make_item(OP_LOAD, 7, KIND_SPHERE, 0, 0, 0, 0, 0, 0, ONE, 0));
      settle();
      csr_write(CSR_OBJECT_COUNT, 8);

      send(make_item(OP_QUERY, 0, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 10 * ONE, 3 * ONE, ONE, 0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 10 * ONE, ONE, 5 * ONE, 0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 10 * ONE, 5 * ONE, 6 * ONE, 0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 10 * ONE, -4 * ONE, -3 * ONE, 0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                     0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     0, 0, 0, 0, 0));
      send(make_item(OP_QUERY, 0, KIND_SPHERE, 40 * ONE, 60 * ONE, -30 * ONE, 0, 0, 0, 0, 0));
      settle();

      // fill every slot so that any count stays within written objects
      for (int s = 0; s < MAX_OBJECTS; s++) send(rand_item(OP_LOAD, s));
      settle();

      for (int p = 0; p < 5; p++) begin
         csr_write(CSR_OBJECT_COUNT, ph_count[p]);
         csr_write(CSR_RENDER_DISTANCE, ph_render[p]);
         send_idle_pct = ph_idle[p];
         stall_pct = ph_stall[p];
         // long hold-off on the result side while queries keep coming
         if (p == 0) hold_left = 3000;
         for (int n = 0; n < ph_items[p]; n++)
            send(rand_item($urandom_range(1) ? OP_QUERY : OP_LOAD, $urandom_range(63)));
         settle();
      end

      $display("run covered %0d loads and %0d queries (%0d hits), counts 0 to 127,",
               load_total, query_total, hit_count);
      $display("render distances from 0 to full scale, with sender gaps and receiver stalls");
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule
